@@ hdl/gsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// gsfd_pkg
// Shared types, character codes and constants for the sentence field display.
// ----------------------------------------------------------------------------
package gsfd_pkg;

   localparam int FIELD_COUNT_DEF = 8;

   localparam int VALUE_W    = 20;
   localparam int PAIR_W     = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 20'd999999;

   localparam logic [7:0] FIELD_START_POS = 8'd7;
   localparam logic [7:0] TAG_POS         = 8'd4;
   localparam logic [7:0] POS_MAX         = 8'd255;
   localparam logic [3:0] FIELD_IDX_MAX   = 4'd15;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_N       = 8'h4E;
   localparam logic [7:0] CHAR_W       = 8'h57;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // Fields that hold a hemisphere letter rather than a number.
   localparam logic [3:0] LAT_HEMI_FIELD = 4'd4;
   localparam logic [3:0] LON_HEMI_FIELD = 4'd7;
   localparam logic [VALUE_W-1:0] HEMI_NORTH = 20'd2;
   localparam logic [VALUE_W-1:0] HEMI_SOUTH = 20'd3;
   localparam logic [VALUE_W-1:0] HEMI_WEST  = 20'd4;
   localparam logic [VALUE_W-1:0] HEMI_EAST  = 20'd5;

   localparam logic [2:0] VIEW_NONE = 3'd7;

   // Reciprocals for the constant divisions: floor(v * RECIP >> SHIFT) is exact
   // over the whole value range of each operand.
   localparam int          DIV_10000_SHIFT = 34;
   localparam logic [20:0] RECIP_10000     = 21'd1717987;
   localparam logic [13:0] PAIR_HIGH_SCALE = 14'd10000;
   localparam int          DIV_100_SHIFT   = 20;
   localparam logic [13:0] RECIP_100       = 14'd10486;
   localparam logic [6:0]  PAIR_MID_SCALE  = 7'd100;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
   } sel_type;

   // View 0 shows field 0; views 1 to 6 show fields 2 to 7.
   function automatic logic [3:0] view_to_field(input logic [2:0] view);
      logic [3:0] field;
      field = (view == 3'd0) ? 4'd0 : ({1'b0, view} + 4'd1);
      return field;
   endfunction

endpackage

@@ hdl/gsfd_parse.sv @@
// ----------------------------------------------------------------------------
// gsfd_parse
// Sentence parser: tracks position and fields, keeps the field values and
// registers the selected field at the end of each valid sentence.
// ----------------------------------------------------------------------------
module gsfd_parse #(
   parameter int FIELD_COUNT = gsfd_pkg::FIELD_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        rx_byte,
   input  logic [2:0]        view_select,
   output gsfd_pkg::sel_type sel_out,
   input  logic              sel_ready
);

   localparam int VW = gsfd_pkg::VALUE_W;

   logic [7:0]    byte_position_ff, byte_position_in;
   logic          sentence_valid_ff, sentence_valid_in;
   logic [3:0]    field_index_ff, field_index_in;
   logic [VW-1:0] field_accum_ff, field_accum_in;
   logic          digits_stopped_ff, digits_stopped_in;
   logic [7:0]    field_lead_char_ff, field_lead_char_in;
   logic [VW-1:0] field_store_ff [FIELD_COUNT];
   logic          sel_valid_ff, sel_valid_in;
   logic [VW-1:0] sel_value_ff, sel_value_in;

   logic          accept;
   logic          in_fields;
   logic          is_newline;
   logic          is_delim;
   logic          is_digit;
   logic          field_end;
   logic [VW-1:0] finish_value;
   logic [23:0]   accum_next;
   logic [3:0]    field_sel;
   logic          field_in_range;
   logic [VW-1:0] store_read;

   assign req_tready = !sel_valid_ff || sel_ready;
   assign accept     = req_tvalid && req_tready;

   assign in_fields  = byte_position_ff >= gsfd_pkg::FIELD_START_POS;
   assign is_newline = rx_byte == gsfd_pkg::CHAR_NEWLINE;
   assign is_delim   = (rx_byte == gsfd_pkg::CHAR_COMMA) || (rx_byte == gsfd_pkg::CHAR_DOT);
   assign is_digit   = (rx_byte >= gsfd_pkg::CHAR_ZERO) && (rx_byte <= gsfd_pkg::CHAR_NINE);
   assign field_end  = in_fields && (is_newline || is_delim);
   assign accum_next = {4'd0, field_accum_ff} * 24'd10
                     + {16'd0, rx_byte - gsfd_pkg::CHAR_ZERO};

   always_comb begin
      if (field_index_ff == gsfd_pkg::LAT_HEMI_FIELD) begin
         finish_value = (field_lead_char_ff == gsfd_pkg::CHAR_N) ?
                        gsfd_pkg::HEMI_NORTH : gsfd_pkg::HEMI_SOUTH;
      end else if (field_index_ff == gsfd_pkg::LON_HEMI_FIELD) begin
         finish_value = (field_lead_char_ff == gsfd_pkg::CHAR_W) ?
                        gsfd_pkg::HEMI_WEST : gsfd_pkg::HEMI_EAST;
      end else begin
         finish_value = field_accum_ff;
      end
   end

   // The field being closed by this newline is forwarded ahead of the store.
   assign field_sel      = gsfd_pkg::view_to_field(view_select);
   assign field_in_range = {1'b0, field_sel} < 5'(FIELD_COUNT);

   always_comb begin
      store_read = '0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         if (field_sel == 4'(i)) begin
            store_read = field_store_ff[i];
         end
      end
   end

   always_comb begin
      byte_position_in   = byte_position_ff;
      sentence_valid_in  = sentence_valid_ff;
      field_index_in     = field_index_ff;
      field_accum_in     = field_accum_ff;
      digits_stopped_in  = digits_stopped_ff;
      field_lead_char_in = field_lead_char_ff;
      sel_valid_in       = sel_valid_ff && !sel_ready;
      sel_value_in       = sel_value_ff;
      if (accept) begin
         if (is_newline) begin
            byte_position_in   = '0;
            sentence_valid_in  = 1'b0;
            field_index_in     = '0;
            field_accum_in     = '0;
            digits_stopped_in  = 1'b0;
            field_lead_char_in = '0;
            sel_valid_in       = sentence_valid_ff && (view_select != gsfd_pkg::VIEW_NONE);
            if (!field_in_range) begin
               sel_value_in = '0;
            end else if (in_fields && (field_sel == field_index_ff)) begin
               sel_value_in = finish_value;
            end else begin
               sel_value_in = store_read;
            end
         end else begin
            sel_valid_in = 1'b0;
            if (byte_position_ff != gsfd_pkg::POS_MAX) begin
               byte_position_in = byte_position_ff + 8'd1;
            end
            if (byte_position_ff == gsfd_pkg::TAG_POS) begin
               sentence_valid_in = rx_byte == gsfd_pkg::CHAR_G;
            end
            if (in_fields) begin
               if (is_delim) begin
                  if (field_index_ff != gsfd_pkg::FIELD_IDX_MAX) begin
                     field_index_in = field_index_ff + 4'd1;
                  end
                  field_accum_in     = '0;
                  digits_stopped_in  = 1'b0;
                  field_lead_char_in = '0;
               end else begin
                  if (field_lead_char_ff == gsfd_pkg::CHAR_NUL) begin
                     field_lead_char_in = rx_byte;
                  end
                  if (!digits_stopped_ff) begin
                     if (is_digit) begin
                        field_accum_in = (accum_next > {4'd0, gsfd_pkg::VALUE_MAX}) ?
                                         gsfd_pkg::VALUE_MAX : accum_next[VW-1:0];
                     end else begin
                        digits_stopped_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= '0;
         sentence_valid_ff  <= 1'b0;
         field_index_ff     <= '0;
         field_accum_ff     <= '0;
         digits_stopped_ff  <= 1'b0;
         field_lead_char_ff <= '0;
         sel_valid_ff       <= 1'b0;
      end else begin
         byte_position_ff   <= byte_position_in;
         sentence_valid_ff  <= sentence_valid_in;
         field_index_ff     <= field_index_in;
         field_accum_ff     <= field_accum_in;
         digits_stopped_ff  <= digits_stopped_in;
         field_lead_char_ff <= field_lead_char_in;
         sel_valid_ff       <= sel_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_value_ff <= sel_value_in;
   end

   // Every newline clears the kept fields, taking priority over the write.
   always_ff @(posedge clock) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
         if (reset || (accept && is_newline)) begin
            field_store_ff[i] <= '0;
         end else if (accept && field_end && (field_index_ff == 4'(i))) begin
            field_store_ff[i] <= finish_value;
         end
      end
   end

   assign sel_out.valid = sel_valid_ff;
   assign sel_out.value = sel_value_ff;

endmodule

@@ hdl/gsfd_split.sv @@
// ----------------------------------------------------------------------------
// gsfd_split
// Splits the selected value into three base-100 display pairs over two
// registered stages and holds the result for the response channel.
// ----------------------------------------------------------------------------
module gsfd_split (
   input  logic                              clock,
   input  logic                              reset,
   input  gsfd_pkg::sel_type                 sel_in,
   output logic                              sel_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gsfd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int VW = gsfd_pkg::VALUE_W;
   localparam int PW = gsfd_pkg::PAIR_W;

   logic          s2_valid_ff, s2_valid_in;
   logic [VW-1:0] s2_value_ff;
   logic [PW-1:0] s2_high_ff;
   logic [13:0]   s2_rem_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [gsfd_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic          out_ready;
   logic [40:0]   high_prod;
   logic [PW-1:0] high;
   logic [20:0]   high_back;
   logic [20:0]   rem_wide;
   logic [27:0]   mid_prod;
   logic [PW-1:0] mid;
   logic [13:0]   mid_back;
   logic [13:0]   low_wide;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign sel_ready = !s2_valid_ff || out_ready;

   // First stage: the ten-thousands pair and the remainder below 10000.
   assign high_prod = 41'(sel_in.value) * 41'(gsfd_pkg::RECIP_10000);
   assign high      = high_prod[gsfd_pkg::DIV_10000_SHIFT +: PW];
   assign high_back = 21'(high) * 21'(gsfd_pkg::PAIR_HIGH_SCALE);
   assign rem_wide  = 21'(sel_in.value) - high_back;

   // Second stage: hundreds and units pairs from the remainder.
   assign mid_prod = 28'(s2_rem_ff) * 28'(gsfd_pkg::RECIP_100);
   assign mid      = mid_prod[gsfd_pkg::DIV_100_SHIFT +: PW];
   assign mid_back = 14'(mid) * 14'(gsfd_pkg::PAIR_MID_SCALE);
   assign low_wide = s2_rem_ff - mid_back;

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (sel_ready) begin
         s2_valid_in = sel_in.valid;
      end
      if (out_ready) begin
         rsp_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel_ready) begin
         s2_value_ff <= sel_in.value;
         s2_high_ff  <= high;
         s2_rem_ff   <= rem_wide[13:0];
      end
      if (out_ready) begin
         rsp_data_ff <= {7'd0, s2_high_ff, mid, low_wide[PW-1:0], s2_value_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/gga_sentence_field_display_top.sv @@
// ----------------------------------------------------------------------------
// gga_sentence_field_display_top
// Receives sentence characters one per request and, at each newline that
// closes a valid sentence, returns the selected field with its display pairs.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one received character and the view switch
// setting per request. Requests that do not end a sentence, sentences whose
// fifth character is not 'G', and newlines with the view switch at 7 give no
// response. Otherwise the newline request gives exactly one response holding
// the chosen field's value and its low, middle and high base-100 pairs.
// A request is taken in every cycle the request side is ready; the block
// sustains one request per cycle while the response side keeps up. The
// response to a newline passes the parser output register, the register
// after the division by 10000 and the one after the division by 100.
// Reset clears all sentence state and the kept fields, and empties the
// pipeline. When the response side stalls, the stages fill one by one and
// req_tready falls only once the parser output register is also held.
// ----------------------------------------------------------------------------
module gga_sentence_field_display_top #(
   parameter int FIELD_COUNT = gsfd_pkg::FIELD_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] rx_byte, [10:8] view_select, [15:11] zero
   input  logic [gsfd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [19:0] shown_value, [26:20] pair_low, [33:27] pair_mid,
   // [40:34] pair_high, [47:41] zero
   output logic [gsfd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   gsfd_pkg::sel_type sel;
   logic              sel_ready;

   gsfd_parse #(
      .FIELD_COUNT (FIELD_COUNT)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rx_byte     (req_tdata[7:0]),
      .view_select (req_tdata[10:8]),
      .sel_out     (sel),
      .sel_ready   (sel_ready)
   );

   gsfd_split u_split (
      .clock      (clock),
      .reset      (reset),
      .sel_in     (sel),
      .sel_ready  (sel_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hdl/gsfd_check.sv @@
// ----------------------------------------------------------------------------
// gsfd_check
// Port-level checks for the sentence field display, bound to the top level.
// ----------------------------------------------------------------------------
module gsfd_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gsfd_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gsfd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // The response side is empty in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A waiting request is held unchanged until it is taken.
   assert property (@(posedge clock) disable iff (reset)
                    req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request changed while waiting");

   // A held response stays valid until it is taken.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // The low and middle display pairs are proper base-100 digits.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> (rsp_tdata[26:20] < 7'd100) &&
                                   (rsp_tdata[33:27] < 7'd100))
      else $error("display pair out of range");

   // The pairs recompose the shown value.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> (34'(rsp_tdata[40:34]) * 34'd10000 +
                                    34'(rsp_tdata[33:27]) * 34'd100 +
                                    34'(rsp_tdata[26:20])) == 34'(rsp_tdata[19:0]))
      else $error("display pairs do not match the value");

endmodule

bind gga_sentence_field_display_top gsfd_check u_gsfd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
